### hdl/ftw_pkg.sv
// ----------------------------------------------------------------------------
// ftw_pkg
// Types and constants shared by the frame time window monitor.
// ----------------------------------------------------------------------------
package ftw_pkg;

  localparam int unsigned FILL_W  = 13;
  localparam int unsigned FRAME_W = 24;
  localparam int unsigned PCT_W   = 10;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned PROD_W  = FILL_W + PCT_W + 1;

  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(1000);

  // divide by 1000 as multiply by ceil(2^33 / 1000) and shift right by 33
  localparam logic [PROD_W-1:0] RECIP_MUL   = 24'd8589935;
  localparam int unsigned       RECIP_SHIFT = 33;

  localparam logic [2:0] REG_WINDOW_SIZE  = 3'd0;
  localparam logic [2:0] REG_HITCH_THRESH = 3'd1;
  localparam logic [2:0] REG_EMIT_INTVL   = 3'd2;
  localparam logic [2:0] REG_PCT_COUNT    = 3'd3;
  localparam logic [2:0] REG_PCT_A        = 3'd4;
  localparam logic [2:0] REG_PCT_B        = 3'd5;
  localparam logic [2:0] REG_PCT_C        = 3'd6;

  localparam logic [1:0] RES_HITCH = 2'd0;
  localparam logic [1:0] RES_PCT   = 2'd1;
  localparam logic [1:0] RES_TOTAL = 2'd2;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [23:0] frame_us;
    logic [15:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  slot;
    logic [31:0] value;
    logic        has_reason;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic              hitch;
    logic [23:0]       frame;
    logic              summ;
    logic              reason;
    logic [FILL_W-1:0] n;
    logic [31:0]       total;
  } job_t;

  typedef struct packed {
    logic [9:0]  window_size;
    logic [23:0] hitch_thresh;
    logic [23:0] emit_intvl;
  } front_cfg_t;

  typedef struct packed {
    logic [1:0]            pct_count;
    logic [2:0][PCT_W-1:0] pct;
  } back_cfg_t;

endpackage

### hdl/ftw_ram.sv
// ----------------------------------------------------------------------------
// ftw_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ftw_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ftw_fifo.sv
// ----------------------------------------------------------------------------
// ftw_fifo
// Small register queue carrying one struct per entry.
// ----------------------------------------------------------------------------
module ftw_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  T                entry_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= data_i;
    end
  end

endmodule

### hdl/ftw_front.sv
// ----------------------------------------------------------------------------
// ftw_front
// Takes input items, writes the window, keeps the counters, issues jobs.
// ----------------------------------------------------------------------------
module ftw_front #(
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ftw_pkg::front_cfg_t  cfg_i,
  input  logic                 push_i,
  input  ftw_pkg::in_item_t    item_i,
  output logic                 full_o,
  input  logic                 job_empty_i,
  input  logic                 back_busy_i,
  output logic                 job_push_o,
  output ftw_pkg::job_t        job_o,
  output logic                 we_o,
  output logic [AW-1:0]        waddr_o,
  output logic [23:0]          wdata_o
);
  import ftw_pkg::*;

  logic [FILL_W-1:0] fill_q, fill_d, size_w;
  logic [AW-1:0]     cur_q, cur_d, cur_w, ncur_w;
  logic [31:0]       total_q, total_d, acc_q, acc_d, acc_sum;
  logic [32:0]       acc_wide;
  logic              accept, hitch, summ;

  assign full_o = !(job_empty_i && !back_busy_i);
  assign accept = push_i && !full_o;

  always_comb begin
    if (32'(cfg_i.window_size) > 32'(DEPTH)) begin
      size_w = FILL_W'(DEPTH);
    end else if (cfg_i.window_size == '0) begin
      size_w = FILL_W'(1);
    end else begin
      size_w = FILL_W'(cfg_i.window_size);
    end
  end

  assign acc_wide = {1'b0, acc_q} + 33'(item_i.elapsed_ms);
  assign acc_sum  = acc_wide[32] ? 32'hFFFF_FFFF : acc_wide[31:0];

  always_comb begin
    fill_d  = fill_q;
    cur_d   = cur_q;
    total_d = total_q;
    acc_d   = acc_q;
    hitch   = 1'b0;
    summ    = 1'b0;
    we_o    = 1'b0;
    waddr_o = '0;
    cur_w   = (32'(cur_q) >= 32'(fill_q)) ? '0 : cur_q;
    ncur_w  = cur_w + AW'(1);
    if (accept) begin
      if (item_i.kind == KIND_TICK) begin
        we_o = 1'b1;
        if (fill_q < size_w) begin
          waddr_o = AW'(fill_q);
          fill_d  = fill_q + FILL_W'(1);
          if (fill_d >= size_w) begin
            cur_d = '0;
          end
        end else begin
          waddr_o = cur_w;
          cur_d   = (32'(cur_w) + 32'd1 >= 32'(fill_q)) ? '0 : ncur_w;
        end
        if (item_i.frame_us >= cfg_i.hitch_thresh) begin
          hitch = 1'b1;
          if (total_q != 32'hFFFF_FFFF) begin
            total_d = total_q + 32'd1;
          end
        end
        if (cfg_i.emit_intvl != '0) begin
          acc_d = acc_sum;
          if (acc_sum >= 32'(cfg_i.emit_intvl)) begin
            acc_d = '0;
            summ  = 1'b1;
          end
        end
      end else begin
        summ   = (fill_q != '0);
        fill_d = '0;
        cur_d  = '0;
      end
    end
    job_o.hitch  = hitch;
    job_o.frame  = item_i.frame_us;
    job_o.summ   = summ;
    job_o.reason = (item_i.kind == KIND_TICK);
    job_o.n      = (item_i.kind == KIND_TICK) ? fill_d : fill_q;
    job_o.total  = total_d;
    if (summ) begin
      total_d = '0;
    end
  end

  assign job_push_o = accept && (hitch || summ);
  assign wdata_o    = item_i.frame_us;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      cur_q   <= '0;
      total_q <= '0;
      acc_q   <= '0;
    end else begin
      fill_q  <= fill_d;
      cur_q   <= cur_d;
      total_q <= total_d;
      acc_q   <= acc_d;
    end
  end

endmodule

### hdl/ftw_back.sv
// ----------------------------------------------------------------------------
// ftw_back
// Carries out jobs: hitch results and radix-select percentile summaries.
// ----------------------------------------------------------------------------
module ftw_back #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned SLOTS = 3,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ftw_pkg::back_cfg_t  cfg_i,
  input  logic                job_empty_i,
  input  ftw_pkg::job_t       job_i,
  output logic                job_pop_o,
  output logic                busy_o,
  output logic                re_o,
  output logic [AW-1:0]       raddr_o,
  input  logic [23:0]         rdata_i,
  input  logic                res_full_i,
  output logic                res_push_o,
  output ftw_pkg::out_item_t  res_o
);
  import ftw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_HITCH, ST_START, ST_DIV, ST_IDX, ST_SEL, ST_PCT, ST_TOT
  } state_e;

  state_e              state_q;
  job_t                job_q;
  logic [1:0]          slot_q, slots_w;
  logic [PROD_W-1:0]   prod_q;
  logic [PROD_W-1:0]   quo_q;
  logic [2*PROD_W-1:0] quo_full;
  logic [4:0]          bit_q;
  logic [23:0]         prefix_q, hmask;
  logic [FILL_W-1:0]   k_q, cnt_q, j_q, idx_w;
  logic                rdv_q, match;
  logic [PCT_W-1:0]    pct_w;

  assign slots_w  = (32'(cfg_i.pct_count) > 32'(SLOTS)) ? 2'(SLOTS) : cfg_i.pct_count;
  assign pct_w    = (cfg_i.pct[slot_q] > PCT_MAX) ? PCT_MAX : cfg_i.pct[slot_q];
  assign quo_full = (2*PROD_W)'(prod_q) * (2*PROD_W)'(RECIP_MUL);
  assign hmask    = 24'(25'h1FF_FFFF << (bit_q + 5'd1));
  assign match    = (((rdata_i ^ prefix_q) & hmask) == '0) && !rdata_i[bit_q];

  always_comb begin
    if (quo_q == '0) begin
      idx_w = '0;
    end else if (quo_q - PROD_W'(1) > PROD_W'(job_q.n - FILL_W'(1))) begin
      idx_w = job_q.n - FILL_W'(1);
    end else begin
      idx_w = FILL_W'(quo_q - PROD_W'(1));
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign job_pop_o = (state_q == ST_IDLE) && !job_empty_i;
  assign re_o      = (state_q == ST_SEL) && (j_q < job_q.n);
  assign raddr_o   = AW'(j_q);

  always_comb begin
    res_push_o       = 1'b0;
    res_o.result_kind = RES_HITCH;
    res_o.slot       = '0;
    res_o.value      = 32'(job_q.frame);
    res_o.has_reason = 1'b0;
    res_o.last       = !job_q.summ;
    unique case (state_q)
      ST_HITCH: res_push_o = 1'b1;
      ST_PCT: begin
        res_push_o        = 1'b1;
        res_o.result_kind = RES_PCT;
        res_o.slot        = slot_q;
        res_o.value       = 32'(prefix_q);
        res_o.has_reason  = job_q.reason;
        res_o.last        = 1'b0;
      end
      ST_TOT: begin
        res_push_o        = 1'b1;
        res_o.result_kind = RES_TOTAL;
        res_o.value       = job_q.total;
        res_o.has_reason  = job_q.reason;
        res_o.last        = 1'b1;
      end
      default: res_push_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      job_q    <= '0;
      slot_q   <= '0;
      prod_q   <= '0;
      quo_q    <= '0;
      bit_q    <= '0;
      prefix_q <= '0;
      k_q      <= '0;
      cnt_q    <= '0;
      j_q      <= '0;
      rdv_q    <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (!job_empty_i) begin
            job_q  <= job_i;
            slot_q <= '0;
            if (job_i.hitch) begin
              state_q <= ST_HITCH;
            end else if (job_i.summ) begin
              state_q <= ST_START;
            end
          end
        end
        ST_HITCH: begin
          if (!res_full_i) begin
            state_q <= job_q.summ ? ST_START : ST_IDLE;
          end
        end
        ST_START: begin
          if (slot_q < slots_w) begin
            prod_q  <= PROD_W'(pct_w) * PROD_W'(job_q.n) + PROD_W'(999);
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_TOT;
          end
        end
        ST_DIV: begin
          quo_q   <= PROD_W'(quo_full >> RECIP_SHIFT);
          state_q <= ST_IDX;
        end
        ST_IDX: begin
          k_q      <= idx_w;
          bit_q    <= 5'd23;
          prefix_q <= '0;
          j_q      <= '0;
          cnt_q    <= '0;
          rdv_q    <= 1'b0;
          state_q  <= ST_SEL;
        end
        ST_SEL: begin
          rdv_q <= re_o;
          if (re_o) begin
            j_q <= j_q + FILL_W'(1);
          end
          if (rdv_q && match) begin
            cnt_q <= cnt_q + FILL_W'(1);
          end
          if (!re_o && !rdv_q) begin
            if (k_q >= cnt_q) begin
              prefix_q[bit_q] <= 1'b1;
              k_q             <= k_q - cnt_q;
            end
            j_q   <= '0;
            cnt_q <= '0;
            if (bit_q == '0) begin
              state_q <= ST_PCT;
            end else begin
              bit_q <= bit_q - 5'd1;
            end
          end
        end
        ST_PCT: begin
          if (!res_full_i) begin
            slot_q  <= slot_q + 2'd1;
            state_q <= ST_START;
          end
        end
        ST_TOT: begin
          if (!res_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### hdl/frame_time_window_percentile_monitor_unit.sv
// ----------------------------------------------------------------------------
// frame_time_window_percentile_monitor_unit
// Sliding window frame time monitor with hitch and percentile reporting.
// ----------------------------------------------------------------------------
// Items are taken one at a time: the input reads full while a job is queued or
// the back end is busy. A sample that gives no result leaves the input free for
// the next one; one that gives only a hitch result holds it until the result
// is written, which waits while the result queue is full. A summary walks the
// window RAM through its single read port once per bit of the 24-bit frame
// time for every percentile slot.
module frame_time_window_percentile_monitor_unit #(
  parameter int unsigned WINDOW_DEPTH     = 512,
  parameter int unsigned PERCENTILE_SLOTS = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [23:0]          cfg_data_i,
  input  logic                 push,
  input  ftw_pkg::in_item_t    in_i,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output ftw_pkg::out_item_t   out_o
);
  import ftw_pkg::*;

  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  front_cfg_t    fcfg_q;
  back_cfg_t     bcfg_q;
  logic          job_empty, job_full, job_push, job_pop, back_busy;
  job_t          job_in, job_out;
  logic          we, re, res_full, res_push;
  logic [AW-1:0] waddr, raddr;
  logic [23:0]   wdata, rdata;
  out_item_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcfg_q.window_size  <= 10'd512;
      fcfg_q.hitch_thresh <= 24'd100000;
      fcfg_q.emit_intvl   <= 24'd30000;
      bcfg_q.pct_count    <= 2'd3;
      bcfg_q.pct[0]       <= 10'd500;
      bcfg_q.pct[1]       <= 10'd900;
      bcfg_q.pct[2]       <= 10'd990;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_SIZE:  fcfg_q.window_size  <= cfg_data_i[9:0];
        REG_HITCH_THRESH: fcfg_q.hitch_thresh <= cfg_data_i;
        REG_EMIT_INTVL:   fcfg_q.emit_intvl   <= cfg_data_i;
        REG_PCT_COUNT:    bcfg_q.pct_count    <= cfg_data_i[1:0];
        REG_PCT_A:        bcfg_q.pct[0]       <= cfg_data_i[9:0];
        REG_PCT_B:        bcfg_q.pct[1]       <= cfg_data_i[9:0];
        REG_PCT_C:        bcfg_q.pct[2]       <= cfg_data_i[9:0];
        default:          fcfg_q              <= fcfg_q;
      endcase
    end
  end

  ftw_front #(.DEPTH(WINDOW_DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (fcfg_q),
    .push_i      (push),
    .item_i      (in_i),
    .full_o      (full),
    .job_empty_i (job_empty),
    .back_busy_i (back_busy),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata)
  );

  ftw_fifo #(.T(job_t), .DEPTH(2)) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  ftw_ram #(.WIDTH(24), .DEPTH(WINDOW_DEPTH)) u_window (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ftw_back #(.DEPTH(WINDOW_DEPTH), .SLOTS(PERCENTILE_SLOTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (bcfg_q),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .busy_o      (back_busy),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  ftw_fifo #(.T(out_item_t), .DEPTH(4)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push && !job_full),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_o),
    .empty_o (empty)
  );

endmodule

### tb/frame_time_window_percentile_monitor_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_time_window_percentile_monitor_unit_tb
// Drives frame samples and flushes into the monitor and checks each result
// transaction against a behavioural window model with rank selection.
// ----------------------------------------------------------------------------
module frame_time_window_percentile_monitor_unit_tb;
  import ftw_pkg::*;

  localparam int unsigned DEPTH = 512;
  localparam int unsigned SLOTS = 3;
  localparam int unsigned STALL_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic push = 1'b0;
  in_item_t in_i = '0;
  logic full;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_o;

  frame_time_window_percentile_monitor_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .push(push), .in_i(in_i), .full(full),
    .empty(empty), .pop(pop), .out_o(out_o)
  );

  always #5 clk_i = ~clk_i;

  // model state
  logic [23:0] win_q [DEPTH];
  int unsigned fill_cnt, cursor;
  logic [31:0] hitch_cnt, time_acc;
  int unsigned win_size, n_slots;
  logic [23:0] hitch_thr, emit_ms;
  int unsigned pct [SLOTS];

  out_item_t expected_q[$];
  int unsigned mismatches = 0;
  bit timed_out = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;
  bit recv_hold = 1'b0;

  function automatic logic [23:0] rank_value(int unsigned n, int unsigned k);
    logic [23:0] sorted[$];
    for (int i = 0; i < n; i++) sorted.push_back(win_q[i]);
    sorted.sort();
    return sorted[k];
  endfunction

  function automatic void add_summary(logic reason);
    int unsigned n, c, idx, p;
    n = fill_cnt;
    for (int s = 0; s < n_slots; s++) begin
      out_item_t r;
      r = '0;
      r.result_kind = RES_PCT;
      r.slot = 2'(s);
      r.has_reason = reason;
      if (n > 0) begin
        p = (pct[s] > 1000) ? 1000 : pct[s];
        c = (p * n + 999) / 1000;
        idx = (c == 0) ? 0 : c - 1;
        if (idx > n - 1) idx = n - 1;
        r.value = 32'(rank_value(n, idx));
      end
      expected_q.push_back(r);
    end
    begin
      out_item_t t;
      t = '0;
      t.result_kind = RES_TOTAL;
      t.value = hitch_cnt;
      t.has_reason = reason;
      expected_q.push_back(t);
    end
    hitch_cnt = '0;
  endfunction

  function automatic void predict_item(in_item_t it);
    int unsigned n_prior, sz;
    logic [32:0] sum;
    n_prior = expected_q.size();
    if (it.kind == KIND_TICK) begin
      sz = (win_size < 1) ? 1 : (win_size > DEPTH ? DEPTH : win_size);
      if (fill_cnt < sz) begin
        win_q[fill_cnt] = it.frame_us;
        fill_cnt++;
        if (fill_cnt >= sz) cursor = 0;
      end else begin
        if (cursor >= fill_cnt) cursor = 0;
        win_q[cursor] = it.frame_us;
        cursor++;
        if (cursor >= fill_cnt) cursor = 0;
      end
      if (it.frame_us >= hitch_thr) begin
        out_item_t h;
        if (hitch_cnt != '1) hitch_cnt++;
        h = '0;
        h.result_kind = RES_HITCH;
        h.value = 32'(it.frame_us);
        expected_q.push_back(h);
      end
      if (emit_ms != 0) begin
        sum = {1'b0, time_acc} + it.elapsed_ms;
        time_acc = sum[32] ? '1 : sum[31:0];
        if (time_acc >= emit_ms) begin
          time_acc = '0;
          add_summary(1'b1);
        end
      end
    end else begin
      if (fill_cnt > 0) add_summary(1'b0);
      fill_cnt = 0;
      cursor = 0;
    end
    if (expected_q.size() > n_prior) expected_q[$].last = 1'b1;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_WINDOW_SIZE: win_size = data[9:0];
      REG_HITCH_THRESH: hitch_thr = data;
      REG_EMIT_INTVL: emit_ms = data;
      REG_PCT_COUNT: n_slots = (data[1:0] > SLOTS) ? SLOTS : data[1:0];
      REG_PCT_A: pct[0] = data[9:0];
      REG_PCT_B: pct[1] = data[9:0];
      REG_PCT_C: pct[2] = data[9:0];
      default: ;
    endcase
  endtask

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (full);
    predict_item(it);
  endtask

  task automatic drain;
    push <= 1'b0;
    while (expected_q.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (40000) @(posedge clk_i);
  endtask

  function automatic in_item_t make_tick(logic [23:0] f, logic [15:0] e);
    in_item_t it;
    it.kind = KIND_TICK;
    it.frame_us = f;
    it.elapsed_ms = e;
    return it;
  endfunction

  function automatic in_item_t make_flush();
    in_item_t it;
    it.kind = KIND_FLUSH;
    it.frame_us = 24'($urandom());
    it.elapsed_ms = 16'($urandom());
    return it;
  endfunction

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction %p", out_o);
        end else begin
          out_item_t e;
          e = expected_q.pop_front();
          if (out_o !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", e, out_o);
          end
        end
      end
      pop <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      timed_out = 1'b1;
      $display("TB_ERROR");
      $finish;
    end
  end

  typedef struct {
    in_item_t it;
    bit checked;
    out_item_t res;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    out_item_t got_first;
    win_size = 512; hitch_thr = 24'd100000; emit_ms = 24'd30000; n_slots = 3;
    pct[0] = 500; pct[1] = 900; pct[2] = 990;
    fill_cnt = 0; cursor = 0; hitch_cnt = '0; time_acc = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: flush of empty window, extremes, hitches, periodic summary
    row.checked = 0; row.res = '0;
    row.it = make_flush(); rows.push_back(row);
    row.it = make_tick(24'hFFFFFF, 16'h0000); row.checked = 1;
    row.res = '{result_kind: RES_HITCH, slot: 2'd0, value: 32'h00FFFFFF,
                has_reason: 1'b0, last: 1'b1};
    rows.push_back(row);
    row.checked = 0;
    row.it = make_tick(24'd0, 16'hFFFF); rows.push_back(row);
    row.it = make_tick(24'd99999, 16'd1); rows.push_back(row);
    row.it = make_tick(24'd100000, 16'd29999); rows.push_back(row);
    row.it = make_flush(); rows.push_back(row);
    row.it = make_flush(); rows.push_back(row);
    foreach (rows[i]) begin
      send_item(rows[i].it);
      if (rows[i].checked) got_first = expected_q[$];
      if (rows[i].checked && got_first !== rows[i].res) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d: expected %p", i, rows[i].res);
      end
    end
    drain();

    // small window, extreme percentiles, largest emit interval
    write_reg(REG_WINDOW_SIZE, 24'd0);
    write_reg(REG_PCT_A, 24'd0);
    write_reg(REG_PCT_B, 24'd1000);
    write_reg(REG_PCT_C, 24'd1023);
    write_reg(REG_HITCH_THRESH, 24'd0);
    write_reg(REG_EMIT_INTVL, 24'hFFFFFF);
    for (int i = 0; i < 6; i++) send_item(make_tick(24'($urandom()), 16'hFFFF));
    send_item(make_flush());
    drain();
    write_reg(REG_WINDOW_SIZE, 24'd7);
    write_reg(REG_EMIT_INTVL, 24'd0);
    write_reg(REG_PCT_COUNT, 24'd0);
    for (int i = 0; i < 10; i++) send_item(make_tick(24'($urandom()), 16'($urandom())));
    send_item(make_flush());
    drain();

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_WINDOW_SIZE, ph == 3 ? 24'd1023 : 24'($urandom_range(1, 12)));
      write_reg(REG_HITCH_THRESH, 24'($urandom_range(1000, 20000)));
      write_reg(REG_EMIT_INTVL, 24'($urandom_range(100, 400)));
      write_reg(REG_PCT_COUNT, 24'($urandom_range(0, 3)));
      write_reg(REG_PCT_A, 24'($urandom_range(0, 1023)));
      write_reg(REG_PCT_B, 24'($urandom_range(0, 1000)));
      write_reg(REG_PCT_C, 24'($urandom_range(0, 1000)));
      send_idle_pct = (ph == 0) ? 30 : (ph == 1 ? 81 : 0);
      recv_idle_pct = (ph == 0) ? 81 : (ph == 1 ? 30 : 0);
      if (ph == 2) begin
        recv_hold = 1'b1;
        fork
          begin
            repeat (3000) @(posedge clk_i);
            recv_hold = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < 25; i++) begin
        logic [23:0] f;
        f = ($urandom_range(3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 30000));
        if ($urandom_range(19) == 0) send_item(make_flush());
        else send_item(make_tick(f, ($urandom_range(9) == 0) ? 16'($urandom())
                                                            : 16'($urandom_range(0, 60))));
      end
      drain();
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();

    if (mismatches == 0 && expected_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

### frame_time_window_percentile_monitor_unit.f
hdl/ftw_pkg.sv
hdl/ftw_ram.sv
hdl/ftw_fifo.sv
hdl/ftw_front.sv
hdl/ftw_back.sv
hdl/frame_time_window_percentile_monitor_unit.sv
tb/frame_time_window_percentile_monitor_unit_tb.sv
